@@ hdl/b91enc_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// b91enc_pkg
// Constants and helpers for the basE91 encoder: alphabet lookup,
// division by 91 and the saturating column add.
// ----------------------------------------------------------------------------
package b91enc_pkg;

  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned QUEUE_W   = 13;
  localparam int unsigned COUNT_W   = 4;
  localparam int unsigned COL_W     = 11;
  localparam int unsigned BREAK_W   = 10;
  localparam int unsigned DIGIT_W   = 7;
  localparam int unsigned VALUE_W   = 14;
  localparam int unsigned SLOT_N    = 6;

  localparam logic [COL_W-1:0]   COL_MAX   = 11'd2047;
  localparam logic [BYTE_W-1:0]  NEWLINE   = 8'h0A;
  localparam logic [12:0]        SMALL_LIM = 13'd88;
  localparam logic [12:0]        FLUSH_LIM = 13'd90;
  localparam logic [13:0]        RADIX     = 14'd91;
  // ceil(2^20 / 91); exact quotient for every 14-bit value
  localparam logic [27:0]        RECIP     = 28'd11523;

  typedef logic [BYTE_W-1:0] char_t;

  function automatic char_t alpha91(input logic [DIGIT_W-1:0] idx);
    char_t ch;
    ch = 8'h41;
    if (idx < 7'd26) begin
      ch = 8'h41 + 8'(idx);
    end else if (idx < 7'd52) begin
      ch = 8'h61 + 8'(idx - 7'd26);
    end else if (idx < 7'd62) begin
      ch = 8'h30 + 8'(idx - 7'd52);
    end else begin
      case (idx)
        7'd62: ch = 8'h21;
        7'd63: ch = 8'h23;
        7'd64: ch = 8'h24;
        7'd65: ch = 8'h25;
        7'd66: ch = 8'h26;
        7'd67: ch = 8'h28;
        7'd68: ch = 8'h29;
        7'd69: ch = 8'h2A;
        7'd70: ch = 8'h2B;
        7'd71: ch = 8'h2C;
        7'd72: ch = 8'h2E;
        7'd73: ch = 8'h2F;
        7'd74: ch = 8'h3A;
        7'd75: ch = 8'h3B;
        7'd76: ch = 8'h3C;
        7'd77: ch = 8'h3D;
        7'd78: ch = 8'h3E;
        7'd79: ch = 8'h3F;
        7'd80: ch = 8'h40;
        7'd81: ch = 8'h5B;
        7'd82: ch = 8'h5D;
        7'd83: ch = 8'h5E;
        7'd84: ch = 8'h5F;
        7'd85: ch = 8'h60;
        7'd86: ch = 8'h7B;
        7'd87: ch = 8'h7C;
        7'd88: ch = 8'h7D;
        7'd89: ch = 8'h7E;
        7'd90: ch = 8'h22;
        default: ch = 8'h41;
      endcase
    end
    return ch;
  endfunction

  // {quotient, remainder} of v / 91; quotient stays below 91 for encoder values
  function automatic logic [2*DIGIT_W-1:0] divmod91(input logic [VALUE_W-1:0] v);
    logic [27:0]        prod;
    logic [7:0]         q;
    logic [VALUE_W-1:0] qm;
    logic [VALUE_W-1:0] r;
    prod = 28'(v) * RECIP;
    q    = prod[27:20];
    qm   = 14'(q) * RADIX;
    r    = v - qm;
    return {q[DIGIT_W-1:0], r[DIGIT_W-1:0]};
  endfunction

  function automatic logic [COL_W-1:0] col_add(input logic [COL_W-1:0] col,
                                               input logic [1:0] k);
    logic [COL_W:0] s;
    s = {1'b0, col} + (COL_W+1)'(k);
    return (s > {1'b0, COL_MAX}) ? COL_MAX : s[COL_W-1:0];
  endfunction

endpackage

@@ hdl/base91_encoder_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base91_encoder_top
// Streaming basE91 encoder: one optional byte per item in, alphabet
// characters and newlines out, one character per handshake on the result side.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i / in_stall_o) carries data_byte_i, has_byte_i and
//   end_of_stream_i. Result channel (out_valid_o / out_stall_i) carries
//   out_char_o and last_of_run_o, which marks the final character of an item.
//   cfg_valid_i / cfg_ready_o writes the line break count (0: no breaks);
//   write it only while the block is idle.
//   An item is captured in an input register, then encoded into a six-slot
//   result register. The result register drains one character per cycle
//   while the receiver does not stall, and the next item loads in the cycle
//   its last character leaves, so the one-character result port sets the
//   pace of the stream.
//   A receiver stall holds the current character and backs up the input
//   channel once the input register is full.
//   Reset clears the bit queue, column count, break count and pending results.
// ----------------------------------------------------------------------------
module base91_encoder_top
  import b91enc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [BREAK_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic               has_byte_i,
  input  logic               end_of_stream_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [BYTE_W-1:0]  out_char_o,
  output logic               last_of_run_o
);

  logic [BREAK_W-1:0] brk_q;
  logic               item_vld_q;
  logic [BYTE_W-1:0]  item_byte_q;
  logic               item_has_q;
  logic               item_eos_q;
  logic [QUEUE_W-1:0] b_q, b_d;
  logic [COUNT_W-1:0] n_q, n_d;
  logic [COL_W-1:0]   col_q, col_d;
  logic [SLOT_N-1:0]  mask_q, mask_d;
  char_t              slot_q [4];
  char_t              slot_d [4];

  logic                 in_acc, out_acc, load;
  logic [20:0]          b_ext;
  logic [4:0]           n1;
  logic                 pair, take13, brk, f0, f1, nl2;
  logic [VALUE_W-1:0]   v;
  logic [QUEUE_W-1:0]   b2;
  logic [COUNT_W-1:0]   n2;
  logic [COL_W-1:0]     col_a, col_b, col_c;
  logic [2*DIGIT_W-1:0] dm_pair, dm_flush;

  assign cfg_ready_o = 1'b1;

  assign out_valid_o = |mask_q;
  assign out_acc     = out_valid_o && !out_stall_i;
  assign load        = item_vld_q && (!out_valid_o || ($onehot(mask_q) && out_acc));
  assign in_stall_o  = item_vld_q && !load;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    b_ext  = 21'(b_q) | (21'(item_byte_q) << n_q);
    n1     = 5'(n_q) + 5'd8;
    pair   = item_has_q && (n1 > 5'd13);
    take13 = b_ext[12:0] > SMALL_LIM;
    v      = take13 ? {1'b0, b_ext[12:0]} : b_ext[13:0];
    if (pair) begin
      b2 = take13 ? 13'(b_ext >> 13) : 13'(b_ext >> 14);
      n2 = take13 ? 4'(n1 - 5'd13) : 4'(n1 - 5'd14);
    end else if (item_has_q) begin
      b2 = b_ext[12:0];
      n2 = n1[3:0];
    end else begin
      b2 = b_q;
      n2 = n_q;
    end
    col_a = pair ? col_add(col_q, 2'd2) : col_q;
    brk   = pair && (brk_q != '0) && (col_a >= 11'(brk_q));
    col_b = brk ? '0 : col_a;
    f0    = item_eos_q && (n2 != '0);
    f1    = f0 && ((n2 > 4'd7) || (b2 > FLUSH_LIM));
    col_c = col_add(col_b, 2'(f0) + 2'(f1));
    nl2   = item_eos_q && (col_c != '0);

    dm_pair  = divmod91(v);
    dm_flush = divmod91({1'b0, b2});
    slot_d[0] = alpha91(dm_pair[DIGIT_W-1:0]);
    slot_d[1] = alpha91(dm_pair[2*DIGIT_W-1:DIGIT_W]);
    slot_d[2] = alpha91(dm_flush[DIGIT_W-1:0]);
    slot_d[3] = alpha91(dm_flush[2*DIGIT_W-1:DIGIT_W]);

    if (item_eos_q) begin
      b_d   = '0;
      n_d   = '0;
      col_d = '0;
    end else begin
      b_d   = b2;
      n_d   = n2;
      col_d = col_b;
    end

    if (load) begin
      mask_d = {nl2, f1, f0, brk, pair, pair};
    end else if (out_acc) begin
      mask_d = mask_q & (mask_q - SLOT_N'(1));
    end else begin
      mask_d = mask_q;
    end
  end

  always_comb begin
    if (mask_q[0]) begin
      out_char_o = slot_q[0];
    end else if (mask_q[1]) begin
      out_char_o = slot_q[1];
    end else if (mask_q[2]) begin
      out_char_o = NEWLINE;
    end else if (mask_q[3]) begin
      out_char_o = slot_q[2];
    end else if (mask_q[4]) begin
      out_char_o = slot_q[3];
    end else begin
      out_char_o = NEWLINE;
    end
    last_of_run_o = $onehot(mask_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      brk_q      <= '0;
      item_vld_q <= 1'b0;
      b_q        <= '0;
      n_q        <= '0;
      col_q      <= '0;
      mask_q     <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        brk_q <= cfg_data_i;
      end
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (load) begin
        item_vld_q <= 1'b0;
      end
      if (load) begin
        b_q   <= b_d;
        n_q   <= n_d;
        col_q <= col_d;
      end
      mask_q <= mask_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_byte_q <= data_byte_i;
      item_has_q  <= has_byte_i;
      item_eos_q  <= end_of_stream_i;
    end
    if (load) begin
      slot_q <= slot_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= 4'd13)
    else $error("bit queue count above 13");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (load && item_eos_q) |=> (b_q == '0 && n_q == '0 && col_q == '0))
    else $error("state not cleared after end of stream");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && last_of_run_o) |=> (mask_q == '0 || $past(load)))
    else $error("results left after last item character");

endmodule

@@ verif/base91_encoder_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base91_encoder_checker
// Watches the break count, input and result channels of the basE91 encoder.
// Keeps its own bit queue, bit count and column, works out the characters
// that each accepted item must produce, and compares every accepted
// character and its end-of-item flag, in order, against that expectation.
// ----------------------------------------------------------------------------
module base91_encoder_checker
  import b91enc_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_valid_i,
  input  logic               cfg_ready_i,
  input  logic [BREAK_W-1:0] cfg_data_i,
  input  logic               in_valid_i,
  input  logic               in_stall_i,
  input  logic [BYTE_W-1:0]  data_byte_i,
  input  logic               has_byte_i,
  input  logic               end_of_stream_i,
  input  logic               out_valid_i,
  input  logic               out_stall_i,
  input  logic [BYTE_W-1:0]  out_char_i,
  input  logic               last_of_run_i,
  output int                 mismatch_cnt_o,
  output int                 chars_pending_o
);

  typedef struct packed {
    logic [BYTE_W-1:0] ch;
    logic              last;
  } enc_char_t;

  localparam logic [91*8-1:0] ALPHABET = {
    "ABCDEFGHIJKLMNOPQRSTUVWXYZ", "abcdefghijklmnopqrstuvwxyz", "0123456789",
    "!#$%&()*+,./:;<=>?@[]^_", 8'h60, "{|}~", 8'h22
  };

  logic [QUEUE_W-1:0] queue_q;
  logic [COUNT_W-1:0] nbits_q;
  logic [COL_W-1:0]   col_q;
  logic [BREAK_W-1:0] brk_q;
  enc_char_t          char_q[$];
  enc_char_t          want;

  function automatic logic [BYTE_W-1:0] alpha_char(input int unsigned idx);
    return ALPHABET[(90 - idx) * 8 +: 8];
  endfunction

  function automatic logic [COL_W-1:0] col_sat(input logic [COL_W-1:0] col,
                                               input int unsigned k);
    int unsigned sum;
    sum = col + k;
    return (sum > 2047) ? 11'd2047 : sum[COL_W-1:0];
  endfunction

  task automatic encode_item(input logic [BYTE_W-1:0] data, input logic has,
                             input logic eos);
    logic [21:0]        bits;
    int unsigned        nbits;
    logic [VALUE_W-1:0] val;
    logic [COL_W-1:0]   col;
    logic [BYTE_W-1:0]  chars[6];
    int                 cnt;
    bits  = {9'd0, queue_q};
    nbits = nbits_q;
    col   = col_q;
    cnt   = 0;
    if (has) begin
      bits  = bits | (22'(data) << nbits);
      nbits = nbits + 8;
      if (nbits > 13) begin
        if (bits[12:0] > 13'd88) begin
          val   = {1'b0, bits[12:0]};
          bits  = bits >> 13;
          nbits = nbits - 13;
        end else begin
          val   = bits[13:0];
          bits  = bits >> 14;
          nbits = nbits - 14;
        end
        chars[cnt] = alpha_char(val % 91);
        cnt++;
        chars[cnt] = alpha_char((val / 91) % 91);
        cnt++;
        col = col_sat(col, 2);
        if (brk_q != 0 && col >= brk_q) begin
          chars[cnt] = NEWLINE;
          cnt++;
          col = '0;
        end
      end
    end
    if (eos) begin
      if (nbits != 0) begin
        chars[cnt] = alpha_char(bits % 91);
        cnt++;
        col = col_sat(col, 1);
        if (nbits > 7 || bits > 90) begin
          chars[cnt] = alpha_char((bits / 91) % 91);
          cnt++;
          col = col_sat(col, 1);
        end
      end
      if (col != 0) begin
        chars[cnt] = NEWLINE;
        cnt++;
      end
      bits  = '0;
      nbits = 0;
      col   = '0;
    end
    queue_q = bits[QUEUE_W-1:0];
    nbits_q = nbits[COUNT_W-1:0];
    col_q   = col;
    for (int i = 0; i < cnt; i++) begin
      char_q.push_back('{ch: chars[i], last: (i == cnt - 1)});
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      queue_q         = '0;
      nbits_q         = '0;
      col_q           = '0;
      brk_q           = '0;
      char_q.delete();
      mismatch_cnt_o  = 0;
      chars_pending_o = 0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        brk_q = cfg_data_i;
      end
      if (in_valid_i && !in_stall_i) begin
        encode_item(data_byte_i, has_byte_i, end_of_stream_i);
      end
      if (out_valid_i && !out_stall_i) begin
        if (char_q.size() == 0) begin
          mismatch_cnt_o++;
          $display("%0t: unexpected character: expected none, actual %h last %b",
                   $time, out_char_i, last_of_run_i);
        end else begin
          want = char_q.pop_front();
          if (want.ch !== out_char_i) begin
            mismatch_cnt_o++;
            $display("%0t: out_char mismatch: expected %h, actual %h",
                     $time, want.ch, out_char_i);
          end
          if (want.last !== last_of_run_i) begin
            mismatch_cnt_o++;
            $display("%0t: last_of_run mismatch: expected %b, actual %b",
                     $time, want.last, last_of_run_i);
          end
        end
      end
      chars_pending_o = char_q.size();
    end
  end

endmodule

@@ verif/base91_encoder_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// base91_encoder_top_tb
// Drives the basE91 encoder with directed streams (empty ends, zero runs,
// one-byte flushes, break counts of 1, 2 and 1023, a lowered break count
// mid-line, a long line with breaks off) and then random streams under
// random break counts, with random gaps and stalls on both channels. The
// checker beside the block predicts and compares; this module gives the
// verdict.
// ----------------------------------------------------------------------------
module base91_encoder_top_tb;
  import b91enc_pkg::*;

  localparam int CYCLE_LIMIT     = 1_000_000;
  localparam int RANDOM_ITEMS    = 290;
  localparam int SETTLE_CYCLES   = 8;
  localparam int LONG_LINE_BYTES = 60;

  logic               clk_i = 1'b0;
  logic               rst_ni = 1'b0;
  logic               cfg_valid_i;
  logic               cfg_ready_o;
  logic [BREAK_W-1:0] cfg_data_i;
  logic               in_valid_i;
  logic               in_stall_o;
  logic [BYTE_W-1:0]  data_byte_i;
  logic               has_byte_i;
  logic               end_of_stream_i;
  logic               out_valid_o;
  logic               out_stall_i;
  logic [BYTE_W-1:0]  out_char_o;
  logic               last_of_run_o;

  int cycle_cnt = 0;
  int mismatch_cnt;
  int chars_pending;
  bit tx_burst;
  bit rx_burst;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  base91_encoder_top DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_o     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .has_byte_i      (has_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_o      (out_char_o),
    .last_of_run_o   (last_of_run_o)
  );

  base91_encoder_checker u_checker (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_valid_i     (cfg_valid_i),
    .cfg_ready_i     (cfg_ready_o),
    .cfg_data_i      (cfg_data_i),
    .in_valid_i      (in_valid_i),
    .in_stall_i      (in_stall_o),
    .data_byte_i     (data_byte_i),
    .has_byte_i      (has_byte_i),
    .end_of_stream_i (end_of_stream_i),
    .out_valid_i     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .out_char_i      (out_char_o),
    .last_of_run_i   (last_of_run_o),
    .mismatch_cnt_o  (mismatch_cnt),
    .chars_pending_o (chars_pending)
  );

  always @(posedge clk_i) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  // result side: raise a stall of random length before taking each character
  initial begin : result_sink
    int hold;
    out_stall_i = 1'b0;
    forever begin
      @(negedge clk_i);
      hold = rx_burst ? 0 : $urandom_range(0, 16);
      if (hold > 0) begin
        out_stall_i <= 1'b1;
        repeat (hold) @(negedge clk_i);
      end
      out_stall_i <= 1'b0;
      do @(posedge clk_i); while (!out_valid_o);
    end
  end

  function automatic logic [BYTE_W-1:0] pick_byte();
    if ($urandom_range(0, 3) == 0) begin
      return 8'($urandom_range(0, 3));
    end
    return 8'($urandom_range(0, 255));
  endfunction

  // called and returns at a falling edge; valid stays high for a back-to-back item
  task automatic send_item(input logic [BYTE_W-1:0] data, input logic has,
                           input logic eos);
    int gap;
    gap = tx_burst ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid_i      <= 1'b1;
    data_byte_i     <= data;
    has_byte_i      <= has;
    end_of_stream_i <= eos;
    do @(posedge clk_i); while (in_stall_o);
    @(negedge clk_i);
  endtask

  task automatic settle();
    in_valid_i <= 1'b0;
    while (chars_pending != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
  endtask

  task automatic write_break(input logic [BREAK_W-1:0] value);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= value;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  initial begin : stimulus
    int                 n_random;
    int                 len;
    int                 kind;
    logic [BREAK_W-1:0] brk;
    cfg_valid_i     = 1'b0;
    cfg_data_i      = '0;
    in_valid_i      = 1'b0;
    data_byte_i     = '0;
    has_byte_i      = 1'b0;
    end_of_stream_i = 1'b0;
    tx_burst        = 1'b0;
    rx_burst        = 1'b0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    write_break(10'd0);
    // empty end, ignored item, zero run, full bytes, one-byte flush
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hFF, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'h00, 1'b1, 1'b1);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b1);
    send_item(8'h55, 1'b1, 1'b1);

    settle();
    write_break(10'd1);
    repeat (4) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // lower the break count in the middle of a line
    settle();
    write_break(10'd1023);
    repeat (5) send_item(8'hFF, 1'b1, 1'b0);
    settle();
    write_break(10'd2);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'hAA, 1'b0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    // long line with breaks off
    settle();
    write_break(10'd0);
    tx_burst = 1'b1;
    rx_burst = 1'b1;
    repeat (LONG_LINE_BYTES) send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);

    n_random = 0;
    while (n_random < RANDOM_ITEMS) begin
      settle();
      case ($urandom_range(0, 9))
        0:       brk = 10'd0;
        1:       brk = 10'd1023;
        2:       brk = 10'd1;
        3:       brk = 10'd2;
        4:       brk = 10'($urandom_range(0, 1023));
        default: brk = 10'($urandom_range(3, 40));
      endcase
      write_break(brk);
      tx_burst = ($urandom_range(0, 3) == 0);
      rx_burst = ($urandom_range(0, 3) == 0);
      len = $urandom_range(1, 40);
      for (int i = 0; i < len; i++) begin
        kind = $urandom_range(0, 99);
        if (kind < 5) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
        end else if (kind < 10) begin
          send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
          n_random++;
        end else if (kind < 14) begin
          send_item(pick_byte(), 1'b1, 1'b1);
          n_random++;
        end else begin
          send_item(pick_byte(), 1'b1, 1'b0);
          n_random++;
        end
      end
      if ($urandom_range(0, 3) != 0) begin
        send_item(pick_byte(), 1'($urandom_range(0, 1)), 1'b1);
        n_random++;
      end
    end

    settle();
    repeat (20) @(negedge clk_i);
    if (mismatch_cnt == 0 && chars_pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
